// ===== rtl/core/mcdt_pkg.sv =====
`default_nettype none

package mcdt_pkg;

    // Bank size and counter width
    localparam int NUM_TIMERS  = 6;
    localparam int COUNT_WIDTH = 32;
    localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // Fixed field widths of the bus items and the timer registers
    localparam int MODE_W = 2;
    localparam int ADDR_W = 8;
    localparam int DATA_W = 32;
    localparam int IRQ_W  = 6;
    localparam int CTL_W  = 8;
    localparam int PSC_W  = 7;

    // Streaming data widths, padded to whole bytes
    localparam int S_TDATA_W = ((ADDR_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + IRQ_W + 7) / 8) * 8;

    // Control register bits
    localparam int CTL_ENABLE_BIT  = 0;
    localparam int CTL_RELOAD_BIT  = 1;
    localparam int CTL_PSC_LSB     = 4;
    localparam int CTL_PSC_MSB     = 6;
    localparam int CTL_ONESHOT_BIT = 7;

    // Item kinds carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    // Register selected by an address
    typedef enum logic [2:0] {
        REG_NONE,
        REG_IRQ_EN,
        REG_IRQ_STA,
        REG_CTL,
        REG_IVL,
        REG_CNT
    } t_reg_kind;

    // Address offsets
    localparam logic [ADDR_W-1:0] ADDR_IRQ_EN  = 8'h00;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_STA = 8'h04;
    localparam logic [3:0]        OFF_CTL      = 4'h0;
    localparam logic [3:0]        OFF_IVL      = 4'h4;
    localparam logic [3:0]        OFF_CNT      = 4'h8;

    typedef struct packed {
        t_reg_kind               kind;
        logic [TIMER_IDX_W-1:0]  timer;
    } t_dec;

    // Per-timer command for the processing cycle
    typedef struct packed {
        logic tick;
        logic wr_ctl;
        logic wr_ivl;
        logic wr_cnt;
    } t_tmr_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/multi_channel_down_timer_top.sv =====
`default_nettype none

// Bank of down-counting timers behind a small register map. Each input item is
// a timer tick, a register read or a register write (tuser selects which);
// each gives exactly one result item with the read data (zero for anything but
// a mapped read) and the interrupt lines after the item. The block takes one
// item every clock cycle: an item waits in the input register, all timers and
// interrupt bits are updated in the single processing stage that follows, and
// the result lands in the output register, so the throughput of one item per
// cycle is set by that one processing stage. Only back-pressure on the result
// side slows acceptance.
module multi_channel_down_timer_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // tdata: bus_address[7:0], write_data[39:8]
    input  wire logic [mcdt_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // tuser: mode[1:0]
    input  wire logic [mcdt_pkg::MODE_W-1:0]       i_s_tuser,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: read_data[31:0], irq_lines[37:32], zero[39:38]
    output logic [mcdt_pkg::M_TDATA_W-1:0]         o_m_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready
);
    import mcdt_pkg::*;

    // Input register
    logic                   r_in_valid;
    logic [MODE_W-1:0]      r_in_mode;
    logic [ADDR_W-1:0]      r_in_addr;
    logic [DATA_W-1:0]      r_in_wdata;

    // Result register
    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_rdata;
    logic [IRQ_W-1:0]       r_out_irq;

    // Interrupt registers
    logic [NUM_TIMERS-1:0]  r_irq_en, n_irq_en;
    logic [NUM_TIMERS-1:0]  r_irq_pend, n_irq_pend;

    logic                   w_advance;
    logic                   w_proc;
    t_mode                  w_mode;
    t_dec                   w_dec;
    logic                   w_wr;
    logic [DATA_W-1:0]      w_rdata;
    logic [NUM_TIMERS-1:0]  w_fire;
    t_tmr_cmd               w_cmd   [NUM_TIMERS];
    logic [CTL_W-1:0]       w_ctl   [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] w_ivl   [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] w_cnt   [NUM_TIMERS];

    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && w_advance;
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_mode     = t_mode'(r_in_mode);
    assign w_wr       = w_proc && (w_mode == MODE_WRITE);

    mcdt_decode u_decode (
        .i_addr (r_in_addr),
        .o_dec  (w_dec)
    );

    // Timer channels
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
        always_comb begin
            w_cmd[g].tick   = w_proc && (w_mode == MODE_TICK);
            w_cmd[g].wr_ctl = w_wr && (w_dec.kind == REG_CTL)
                              && (w_dec.timer == TIMER_IDX_W'(g));
            w_cmd[g].wr_ivl = w_wr && (w_dec.kind == REG_IVL)
                              && (w_dec.timer == TIMER_IDX_W'(g));
            w_cmd[g].wr_cnt = w_wr && (w_dec.kind == REG_CNT)
                              && (w_dec.timer == TIMER_IDX_W'(g));
        end

        mcdt_timer u_timer (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[g]),
            .i_wdata (r_in_wdata),
            .o_ctl   (w_ctl[g]),
            .o_ivl   (w_ivl[g]),
            .o_cnt   (w_cnt[g]),
            .o_fire  (w_fire[g])
        );
    end

    // Update interrupt enable and pending bits
    always_comb begin
        n_irq_en   = r_irq_en;
        n_irq_pend = r_irq_pend | w_fire;
        if (w_wr && (w_dec.kind == REG_IRQ_EN)) begin
            n_irq_en = r_in_wdata[NUM_TIMERS-1:0];
        end
        if (w_wr && (w_dec.kind == REG_IRQ_STA)) begin
            n_irq_pend = r_irq_pend & ~r_in_wdata[NUM_TIMERS-1:0];
        end
    end

    // Select read data
    always_comb begin
        w_rdata = '0;
        if (w_mode == MODE_READ) begin
            case (w_dec.kind)
                REG_IRQ_EN:  w_rdata = DATA_W'(r_irq_en);
                REG_IRQ_STA: w_rdata = DATA_W'(r_irq_pend);
                REG_CTL:     w_rdata = DATA_W'(w_ctl[w_dec.timer]);
                REG_IVL:     w_rdata = DATA_W'(w_ivl[w_dec.timer]);
                REG_CNT:     w_rdata = DATA_W'(w_cnt[w_dec.timer]);
                default:     w_rdata = '0;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_irq_en    <= '0;
            r_irq_pend  <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_proc) begin
                r_irq_en   <= n_irq_en;
                r_irq_pend <= n_irq_pend;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode  <= i_s_tuser;
            r_in_addr  <= i_s_tdata[ADDR_W-1:0];
            r_in_wdata <= i_s_tdata[ADDR_W+DATA_W-1:ADDR_W];
        end
        if (w_proc) begin
            r_out_rdata <= w_rdata;
            r_out_irq   <= IRQ_W'(n_irq_pend & n_irq_en);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out_irq, r_out_rdata});

endmodule

`default_nettype wire

// ===== rtl/core/mcdt_decode.sv =====
`default_nettype none

module mcdt_decode (
    input  wire logic [mcdt_pkg::ADDR_W-1:0] i_addr,
    output mcdt_pkg::t_dec                   o_dec
);
    import mcdt_pkg::*;

    logic [3:0] w_slot;
    logic [3:0] w_off;

    assign w_slot = i_addr[7:4] - 4'd1;
    assign w_off  = i_addr[3:0];

    // Map a byte offset to a register and a timer index
    always_comb begin
        o_dec.kind  = REG_NONE;
        o_dec.timer = w_slot[TIMER_IDX_W-1:0];
        if (i_addr[1:0] != 2'b00) begin
            o_dec.kind = REG_NONE;
        end else if (i_addr[7:4] == 4'd0) begin
            if (i_addr == ADDR_IRQ_EN) begin
                o_dec.kind = REG_IRQ_EN;
            end else if (i_addr == ADDR_IRQ_STA) begin
                o_dec.kind = REG_IRQ_STA;
            end
        end else if (32'(w_slot) < NUM_TIMERS) begin
            case (w_off)
                OFF_CTL: o_dec.kind = REG_CTL;
                OFF_IVL: o_dec.kind = REG_IVL;
                OFF_CNT: o_dec.kind = REG_CNT;
                default: o_dec.kind = REG_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mcdt_timer.sv =====
`default_nettype none

module mcdt_timer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  mcdt_pkg::t_tmr_cmd                    i_cmd,
    input  wire logic [mcdt_pkg::DATA_W-1:0]      i_wdata,
    output logic [mcdt_pkg::CTL_W-1:0]            o_ctl,
    output logic [mcdt_pkg::COUNT_WIDTH-1:0]      o_ivl,
    output logic [mcdt_pkg::COUNT_WIDTH-1:0]      o_cnt,
    output logic                                  o_fire
);
    import mcdt_pkg::*;

    logic [CTL_W-1:0]       r_ctl, n_ctl;
    logic [COUNT_WIDTH-1:0] r_ivl, n_ivl;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [PSC_W-1:0]       r_psc, n_psc;
    logic [PSC_W:0]         w_psc_inc;
    logic [PSC_W:0]         w_div;

    assign w_psc_inc = {1'b0, r_psc} + {{PSC_W{1'b0}}, 1'b1};
    assign w_div     = {{PSC_W{1'b0}}, 1'b1} << r_ctl[CTL_PSC_MSB:CTL_PSC_LSB];

    // Advance on a tick, or take a register write
    always_comb begin
        n_ctl  = r_ctl;
        n_ivl  = r_ivl;
        n_cnt  = r_cnt;
        n_psc  = r_psc;
        o_fire = 1'b0;
        if (i_cmd.tick && r_ctl[CTL_ENABLE_BIT]) begin
            if (w_psc_inc < w_div) begin
                n_psc = w_psc_inc[PSC_W-1:0];
            end else begin
                n_psc = '0;
                if (r_cnt <= COUNT_WIDTH'(1)) begin
                    o_fire = 1'b1;
                    if (r_ctl[CTL_ONESHOT_BIT]) begin
                        n_cnt                 = '0;
                        n_ctl[CTL_ENABLE_BIT] = 1'b0;
                    end else begin
                        n_cnt = r_ivl;
                    end
                end else begin
                    n_cnt = r_cnt - COUNT_WIDTH'(1);
                end
            end
        end
        if (i_cmd.wr_ctl) begin
            n_ctl                 = i_wdata[CTL_W-1:0];
            n_ctl[CTL_RELOAD_BIT] = 1'b0;
            if (i_wdata[CTL_RELOAD_BIT]) begin
                n_cnt = r_ivl;
                n_psc = '0;
            end
        end
        if (i_cmd.wr_ivl) begin
            n_ivl = i_wdata[COUNT_WIDTH-1:0];
        end
        if (i_cmd.wr_cnt) begin
            n_cnt = i_wdata[COUNT_WIDTH-1:0];
        end
    end

    // Hold timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_ivl <= '0;
            r_cnt <= '0;
            r_psc <= '0;
        end else begin
            r_ctl <= n_ctl;
            r_ivl <= n_ivl;
            r_cnt <= n_cnt;
            r_psc <= n_psc;
        end
    end

    assign o_ctl = r_ctl;
    assign o_ivl = r_ivl;
    assign o_cnt = r_cnt;

endmodule

`default_nettype wire

// ===== rtl/core/mcdt_checker.sv =====
`default_nettype none

module mcdt_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_s_tready,
    input  wire logic [mcdt_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input  wire logic                              o_m_tvalid,
    input  wire logic                              i_m_tready
);
    import mcdt_pkg::*;

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("result payload changed while stalled");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result withdrawn while stalled");

    // With no result waiting the block must take an item
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while result side is free");

    // No result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Padding above the interrupt lines stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[M_TDATA_W-1:DATA_W+IRQ_W] == '0))
        else $error("padding bits set in result");

endmodule

bind multi_channel_down_timer_top mcdt_checker u_mcdt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire
